// ===== hw/rtl/fipg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package fipg_pkg;

  localparam int unsigned NumCards = 4;
  localparam int unsigned CardW    = 4;
  localparam int unsigned IdxW     = 5;
  localparam int unsigned MaxPerms = 24;

  typedef logic [CardW-1:0] card_t;
  typedef logic [IdxW-1:0]  idx_t;
  typedef card_t [NumCards-1:0] card_vec_t;

  typedef struct packed {
    logic load;
    logic sort;
    logic step;
  } fipg_cmd_t;

  typedef struct packed {
    logic last;
  } fipg_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/fipg_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fipg_ctrl
  import fipg_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  output logic              busy_o,
  output fipg_cmd_t         cmd_o,
  input  wire fipg_status_t status_i
);

  typedef enum logic [1:0] {
    StIdle,
    StSort,
    StRun
  } state_e;

  state_e state_q;
  logic   busy_q;

  always_comb begin
    cmd_o      = '0;
    cmd_o.load = (state_q == StIdle) && start_i && !busy_q;
    cmd_o.sort = (state_q == StSort);
    cmd_o.step = (state_q == StRun);
  end

  assign busy_o = busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      busy_q  <= 1'b0;
    end else begin
      case (state_q)
        StIdle: begin
          if (start_i && !busy_q) begin
            state_q <= StSort;
            busy_q  <= 1'b1;
          end
        end
        StSort: begin
          state_q <= StRun;
        end
        StRun: begin
          if (status_i.last) begin
            state_q <= StIdle;
            busy_q  <= 1'b0;
          end
        end
        default: begin
          state_q <= StIdle;
          busy_q  <= 1'b0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/fipg_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fipg_datapath
  import fipg_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire fipg_cmd_t  cmd_i,
  output fipg_status_t    status_o,
  input  wire card_t      card_a_i,
  input  wire card_t      card_b_i,
  input  wire card_t      card_c_i,
  input  wire card_t      card_d_i,
  output logic            strobe_o,
  output card_t           slot_zero_o,
  output card_t           slot_one_o,
  output card_t           slot_two_o,
  output card_t           slot_three_o,
  output idx_t            order_index_o,
  output logic            last_of_run_o
);

  localparam idx_t LastIdx = idx_t'(MaxPerms - 1);

  // compare-exchange network: (0,1) (2,3) (0,2) (1,3) (1,2)
  function automatic card_vec_t sort4(card_vec_t v);
    card_vec_t s;
    card_t     t;
    s = v;
    if (s[1] < s[0]) begin t = s[0]; s[0] = s[1]; s[1] = t; end
    if (s[3] < s[2]) begin t = s[2]; s[2] = s[3]; s[3] = t; end
    if (s[2] < s[0]) begin t = s[0]; s[0] = s[2]; s[2] = t; end
    if (s[3] < s[1]) begin t = s[1]; s[1] = s[3]; s[3] = t; end
    if (s[2] < s[1]) begin t = s[1]; s[1] = s[2]; s[2] = t; end
    return s;
  endfunction

  function automatic logic has_next(card_vec_t v);
    return (v[0] < v[1]) || (v[1] < v[2]) || (v[2] < v[3]);
  endfunction

  // rightmost ascent, swap with rightmost greater, reverse tail
  function automatic card_vec_t next_perm(card_vec_t v);
    card_vec_t n;
    logic [1:0] p;
    logic [1:0] q;
    card_t      piv;
    card_t      t;
    n = v;
    p = 2'd0;
    q = 2'd0;
    for (int j = 1; j < NumCards; j++) begin
      if (v[j-1] < v[j]) p = 2'(j);
    end
    piv = v[p - 2'd1];
    for (int j = 1; j < NumCards; j++) begin
      if ((2'(j) >= p) && (piv < v[j])) q = 2'(j);
    end
    if (p != 2'd0) begin
      t            = n[p - 2'd1];
      n[p - 2'd1]  = n[q];
      n[q]         = t;
      case (p)
        2'd1: begin t = n[1]; n[1] = n[3]; n[3] = t; end
        2'd2: begin t = n[2]; n[2] = n[3]; n[3] = t; end
        default: ;
      endcase
    end
    return n;
  endfunction

  card_vec_t vec_q;
  idx_t      idx_q;
  logic      last_d;
  logic      strobe_q;
  card_vec_t out_vec_q;
  idx_t      out_idx_q;
  logic      out_last_q;

  assign last_d        = !has_next(vec_q) || (idx_q == LastIdx);
  assign status_o.last = last_d;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      vec_q <= {card_d_i, card_c_i, card_b_i, card_a_i};
    end else if (cmd_i.sort) begin
      vec_q <= sort4(vec_q);
      idx_q <= '0;
    end else if (cmd_i.step) begin
      vec_q      <= next_perm(vec_q);
      idx_q      <= idx_q + idx_t'(1);
      out_vec_q  <= vec_q;
      out_idx_q  <= idx_q;
      out_last_q <= last_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= cmd_i.step;
    end
  end

  assign strobe_o      = strobe_q;
  assign slot_zero_o   = out_vec_q[0];
  assign slot_one_o    = out_vec_q[1];
  assign slot_two_o    = out_vec_q[2];
  assign slot_three_o  = out_vec_q[3];
  assign order_index_o = out_idx_q;
  assign last_of_run_o = out_last_q;

endmodule

`default_nettype wire

// ===== hw/rtl/four_item_permutation_generator_core.sv =====
// Four-card lexicographic permutation generator.
// Input: pulse start_i with four 4-bit card values while busy_o is low; the
// item is taken at that edge. busy_o rises on the next cycle and stays high
// until the final permutation has been produced.
// Output: the sorted arrangement first, then each following distinct
// permutation in lexicographic order, one per cycle. Each result is shown
// for one cycle with strobe_o high, carrying its order_index_o and
// last_of_run_o, which marks the final (descending) arrangement.
// The accepted cards are loaded at that edge, sorted in the StSort state, and
// the first result is registered in the first StRun step, raising strobe_o.
// An item yielding N results (1 to 24) keeps busy_o high through the sorting
// network and then one next-permutation step per permutation. A new item can
// be taken in the cycle the last result is shown.
// The receiver cannot stall: results are not held and must be taken as they
// strobe. Reset (rst_ni low, asynchronous) drops any run in progress and
// returns the block to idle with no strobe pending.
`timescale 1ns / 1ps
`default_nettype none

module four_item_permutation_generator_core
  import fipg_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  start_i,
  output logic       busy_o,
  input  wire card_t card_a_i,
  input  wire card_t card_b_i,
  input  wire card_t card_c_i,
  input  wire card_t card_d_i,
  output logic       strobe_o,
  output card_t      slot_zero_o,
  output card_t      slot_one_o,
  output card_t      slot_two_o,
  output card_t      slot_three_o,
  output idx_t       order_index_o,
  output logic       last_of_run_o
);

  fipg_cmd_t    cmd;
  fipg_status_t status;

  fipg_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .busy_o   (busy_o),
    .cmd_o    (cmd),
    .status_i (status)
  );

  fipg_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .card_a_i      (card_a_i),
    .card_b_i      (card_b_i),
    .card_c_i      (card_c_i),
    .card_d_i      (card_d_i),
    .strobe_o      (strobe_o),
    .slot_zero_o   (slot_zero_o),
    .slot_one_o    (slot_one_o),
    .slot_two_o    (slot_two_o),
    .slot_three_o  (slot_three_o),
    .order_index_o (order_index_o),
    .last_of_run_o (last_of_run_o)
  );

`ifndef NO_ASSERTIONS
  a_mid_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !last_of_run_o |-> busy_o)
    else $error("result before end of run while not busy");

  a_index_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !last_of_run_o |=>
      strobe_o && (order_index_o == $past(order_index_o) + idx_t'(1)))
    else $error("run broken or index did not advance");

  a_run_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && last_of_run_o |=> !strobe_o)
    else $error("result after end of run");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o && !strobe_o)
    else $error("accepted item did not raise busy");
`endif

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import fipg_pkg::*;

  localparam int unsigned StallLimit = 400;
  localparam int unsigned DrainCycles = 40;

  typedef struct packed {
    card_t s0;
    card_t s1;
    card_t s2;
    card_t s3;
    idx_t  idx;
    logic  last;
  } perm_t;

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  start_i = 1'b0;
  card_t card_a_i = '0;
  card_t card_b_i = '0;
  card_t card_c_i = '0;
  card_t card_d_i = '0;
  logic  busy_o;
  logic  strobe_o;
  card_t slot_zero_o;
  card_t slot_one_o;
  card_t slot_two_o;
  card_t slot_three_o;
  idx_t  order_index_o;
  logic  last_of_run_o;

  perm_t pending_perms[$];
  int    errors = 0;
  int    items_sent = 0;
  int    perms_checked = 0;
  int    idle_cycles = 0;

  four_item_permutation_generator_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .card_a_i      (card_a_i),
    .card_b_i      (card_b_i),
    .card_c_i      (card_c_i),
    .card_d_i      (card_d_i),
    .strobe_o      (strobe_o),
    .slot_zero_o   (slot_zero_o),
    .slot_one_o    (slot_one_o),
    .slot_two_o    (slot_two_o),
    .slot_three_o  (slot_three_o),
    .order_index_o (order_index_o),
    .last_of_run_o (last_of_run_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Sort, then walk lexicographic successors; push every arrangement.
  function automatic void enumerate_perms(input card_t a, input card_t b,
                                          input card_t c, input card_t d);
    card_t v [NumCards];
    card_t t;
    perm_t p;
    int    k;
    int    m;
    int    asc;
    int    hi;
    int    lo;
    int    up;
    v[0] = a;
    v[1] = b;
    v[2] = c;
    v[3] = d;
    for (int i = 0; i < NumCards - 1; i++) begin
      m = i;
      for (int j = i + 1; j < NumCards; j++) begin
        if (v[j] < v[m]) m = j;
      end
      t = v[i]; v[i] = v[m]; v[m] = t;
    end
    k = 0;
    forever begin
      asc = 0;
      for (int j = 1; j < NumCards; j++) begin
        if (v[j-1] < v[j]) asc = j;
      end
      p.s0 = v[0];
      p.s1 = v[1];
      p.s2 = v[2];
      p.s3 = v[3];
      p.idx = idx_t'(k);
      p.last = (asc == 0) || (k == MaxPerms - 1);
      pending_perms.push_back(p);
      k++;
      if (p.last) break;
      up = asc;
      for (int j = asc; j < NumCards; j++) begin
        if (v[asc-1] < v[j]) up = j;
      end
      t = v[asc-1]; v[asc-1] = v[up]; v[up] = t;
      lo = asc;
      hi = NumCards - 1;
      while (lo < hi) begin
        t = v[lo]; v[lo] = v[hi]; v[hi] = t;
        lo++;
        hi--;
      end
    end
  endfunction

  task automatic report_mismatch(input string what);
    if (errors < 30) $display("%0t MISMATCH: %s", $realtime, what);
    errors++;
  endtask

  always @(posedge clk_i) begin
    perm_t e;
    if (rst_ni && strobe_o) begin
      if (pending_perms.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h %h %h %h idx %0d",
                        slot_zero_o, slot_one_o, slot_two_o, slot_three_o,
                        order_index_o));
      end else begin
        e = pending_perms.pop_front();
        perms_checked++;
        if (slot_zero_o !== e.s0)
          report_mismatch($sformatf("slot_zero %h exp %h (idx %0d)", slot_zero_o, e.s0, e.idx));
        if (slot_one_o !== e.s1)
          report_mismatch($sformatf("slot_one %h exp %h (idx %0d)", slot_one_o, e.s1, e.idx));
        if (slot_two_o !== e.s2)
          report_mismatch($sformatf("slot_two %h exp %h (idx %0d)", slot_two_o, e.s2, e.idx));
        if (slot_three_o !== e.s3)
          report_mismatch($sformatf("slot_three %h exp %h (idx %0d)", slot_three_o, e.s3,
                          e.idx));
        if (order_index_o !== e.idx)
          report_mismatch($sformatf("order_index %0d exp %0d", order_index_o, e.idx));
        if (last_of_run_o !== e.last)
          report_mismatch($sformatf("last_of_run %b exp %b (idx %0d)", last_of_run_o, e.last,
                          e.idx));
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || strobe_o) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= StallLimit) begin
        $display("watchdog: no progress for %0d cycles", idle_cycles);
        $display("tb NOT OK");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic send_item(input card_t a, input card_t b, input card_t c, input card_t d);
    @(negedge clk_i);
    start_i = 1'b1;
    card_a_i = a;
    card_b_i = b;
    card_c_i = c;
    card_d_i = d;
    do @(posedge clk_i); while (busy_o);
    enumerate_perms(a, b, c, d);
    items_sent++;
  endtask

  // start low with junk on the card inputs
  task automatic idle_for(input int n);
    repeat (n) begin
      @(negedge clk_i);
      start_i = 1'b0;
      card_a_i = card_t'($urandom);
      card_b_i = card_t'($urandom);
      card_c_i = card_t'($urandom);
      card_d_i = card_t'($urandom);
    end
  endtask

  task automatic wait_drained();
    idle_for(1);
    while (pending_perms.size() != 0) @(posedge clk_i);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic test_distinct();
    send_item(4'd1, 4'd2, 4'd3, 4'd4);
    send_item(4'd13, 4'd12, 4'd11, 4'd10);
    idle_for(2);
    send_item(4'd7, 4'd1, 4'd13, 4'd5);
    idle_for(1);
  endtask

  task automatic test_repeats();
    send_item(4'd5, 4'd5, 4'd7, 4'd7);
    send_item(4'd3, 4'd3, 4'd3, 4'd9);
    idle_for(3);
    send_item(4'd2, 4'd9, 4'd2, 4'd2);
    send_item(4'd8, 4'd1, 4'd8, 4'd6);
    send_item(4'd13, 4'd13, 4'd1, 4'd1);
    idle_for(1);
  endtask

  task automatic test_all_equal();
    send_item(4'd1, 4'd1, 4'd1, 4'd1);
    send_item(4'd13, 4'd13, 4'd13, 4'd13);
    send_item(4'd0, 4'd0, 4'd0, 4'd0);
    idle_for(5);
    send_item(4'd15, 4'd15, 4'd15, 4'd15);
    idle_for(1);
  endtask

  task automatic test_out_of_range();
    send_item(4'd0, 4'd15, 4'd14, 4'd1);
    send_item(4'd0, 4'd0, 4'd15, 4'd15);
    idle_for(2);
    send_item(4'd14, 4'd0, 4'd14, 4'd0);
    send_item(4'd15, 4'd14, 4'd0, 4'd13);
    idle_for(1);
  endtask

  task automatic test_drain_pause();
    send_item(4'd6, 4'd2, 4'd9, 4'd4);
    wait_drained();
    send_item(4'd9, 4'd9, 4'd2, 4'd4);
    wait_drained();
    send_item(4'd11, 4'd3, 4'd3, 4'd3);
    idle_for(1);
  endtask

  task automatic test_random(input int n);
    card_t c [NumCards];
    card_t x;
    card_t y;
    int    mode;
    for (int i = 0; i < n; i++) begin
      mode = $urandom_range(0, 9);
      x = card_t'($urandom_range(1, 13));
      y = card_t'($urandom_range(1, 13));
      for (int j = 0; j < NumCards; j++) begin
        if (mode < 6) c[j] = card_t'($urandom_range(1, 13));
        else if (mode < 8) c[j] = $urandom_range(0, 1) ? x : y;
        else c[j] = card_t'($urandom);
      end
      send_item(c[0], c[1], c[2], c[3]);
      if ((i / 30) % 3 != 1) idle_for(pick_gap());
      if (i == n / 2) wait_drained();
    end
    idle_for(1);
  endtask

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    idle_for(2);
    test_distinct();
    test_repeats();
    test_all_equal();
    test_out_of_range();
    test_drain_pause();
    test_random(250);
    while (pending_perms.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    $display("%0d card sets sent (sorted, repeated, equal, out-of-range, random)",
             items_sent);
    $display("%0d permutations checked, %0d mismatches", perms_checked, errors);
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
